// ===== rtl/core/pnm_to_rgb_decoder_macros.svh =====
// Assertion helpers for the PNM decoder checks.
`ifndef PNM_TO_RGB_DECODER_MACROS_SVH
`define PNM_TO_RGB_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PNM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PNM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pnm_pkg.sv =====
package pnm_pkg;

  localparam int LINE_LIMIT  = 255;
  localparam int NUMBER_BITS = 16;
  localparam int COL_W       = $clog2(LINE_LIMIT + 1);
  localparam logic [20:0] NUM_LIM =
    21'((((64'd1 << NUMBER_BITS) - 64'd1) < 64'd65535) ?
        ((64'd1 << NUMBER_BITS) - 64'd1) : 64'd65535);

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_ERROR  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] LAST_COMP = 2'd2;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic       step;
    logic [1:0] comp;
  } pnm_cmd_t;

  typedef struct packed {
    logic res_valid;
    logic scale;
    logic three;
  } pnm_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [15:0] acc_digit(input logic [15:0] v, input logic [7:0] c);
    logic [20:0] r;
    r = {2'b0, v, 3'b0} + {4'b0, v, 1'b0} + {13'b0, c - CH_ZERO};
    return (r > NUM_LIM) ? NUM_LIM[15:0] : r[15:0];
  endfunction

endpackage

// ===== rtl/core/pnm_in_if.sv =====
interface pnm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, data_byte, end_of_input, input ready);
  modport sink (input valid, data_byte, end_of_input, output ready);
endinterface

// ===== rtl/core/pnm_out_if.sv =====
interface pnm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] column;
  logic [15:0] row;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        complete;
  logic        last;

  modport source (output valid, kind, red, green, blue, column, row, image_width,
                  image_height, complete, last, input ready);
  modport sink (input valid, kind, red, green, blue, column, row, image_width,
                image_height, complete, last, output ready);
endinterface

// ===== rtl/core/pnm_div.sv =====
// Restoring divider, one quotient bit per cycle; keeps the low 8 quotient bits.
module pnm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [7:0]  quot
);

  logic [23:0] dvd;
  logic [15:0] rem;
  logic [15:0] dsr;
  logic [4:0]  cnt;
  logic        busy;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem, dvd[23]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd24;
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        dvd  <= {dvd[22:0], 1'b0};
        rem  <= fits ? 16'(trial - {1'b0, dsr}) : trial[15:0];
        quot <= {quot[6:0], fits};
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/pnm_ctrl.sv =====
module pnm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pnm_pkg::pnm_status_t st,
  input  logic                 div_done,
  output logic                 div_start,
  output pnm_pkg::pnm_cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DIV, S_OUT} state_t;

  state_t     state;
  logic [1:0] comp;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cmd       = '{step: in_valid && in_ready, comp: comp};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      comp      <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EVAL;
        end
        S_EVAL: begin
          if (!st.res_valid) begin
            state <= S_IDLE;
          end else if (st.scale) begin
            state     <= S_DIV;
            comp      <= '0;
            div_start <= 1'b1;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (st.three && comp != pnm_pkg::LAST_COMP) begin
              comp      <= comp + 2'd1;
              div_start <= 1'b1;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/pnm_dp.sv =====
module pnm_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  pnm_pkg::pnm_cmd_t    cmd,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_input,
  input  logic                 div_done,
  input  logic [7:0]           div_quot,
  output pnm_pkg::pnm_status_t st,
  output logic [23:0]          div_dividend,
  output logic [15:0]          div_divisor,
  output logic [1:0]           kind,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue,
  output logic [15:0]          column,
  output logic [15:0]          row,
  output logic [15:0]          image_width,
  output logic [15:0]          image_height,
  output logic                 complete,
  output logic                 last
);

  typedef enum logic [2:0] {
    PH_MAGIC, PH_DIMS, PH_MAXV, PH_PIXELS, PH_DONE, PH_STOPPED
  } phase_t;

  localparam logic [1:0] MAP_BIT = 2'd0;
  localparam logic [1:0] MAP_PIX = 2'd2;
  localparam logic [1:0] MAP_BAD = 2'd3;

  phase_t                   phase, phase_next;
  logic                     ascii_mode, ascii_mode_next;
  logic [1:0]               map_kind, map_kind_next;
  logic [15:0]              width_reg, width_reg_next;
  logic [15:0]              height_reg, height_reg_next;
  logic [15:0]              max_value, max_value_next;
  logic [15:0]              token_value, token_value_next;
  logic [15:0]              sample_store [3];
  logic [15:0]              sample_store_next [3];
  logic [1:0]               sample_index, sample_index_next;
  logic [15:0]              x_count, x_count_next;
  logic [15:0]              y_count, y_count_next;
  logic [pnm_pkg::COL_W-1:0] line_column, line_column_next;
  logic                     in_comment, in_comment_next;
  logic                     tok_active, tok_active_next;

  logic [15:0] rec_s [3];
  logic [15:0] rec_max;

  // step results
  logic        e_valid;
  logic [1:0]  e_kind;
  logic [15:0] e_col, e_row, e_w, e_h, e_max;
  logic [15:0] e_s [3];
  logic [1:0]  e_map;
  logic        e_complete, e_last;
  logic        do_add, do_check, do_line, comment;
  logic [15:0] add_v;
  logic [pnm_pkg::COL_W-1:0] len;
  logic [2:0]  sidx3;
  logic [1:0]  widx;
  logic [7:0]  k;
  logic [7:0]  bit_rgb;

  assign div_divisor  = rec_max;
  assign div_dividend = {rec_s[cmd.comp], 8'b0} - {8'b0, rec_s[cmd.comp]};

  always_comb begin
    phase_next        = phase;
    ascii_mode_next   = ascii_mode;
    map_kind_next     = map_kind;
    width_reg_next    = width_reg;
    height_reg_next   = height_reg;
    max_value_next    = max_value;
    token_value_next  = token_value;
    sample_store_next = sample_store;
    sample_index_next = sample_index;
    x_count_next      = x_count;
    y_count_next      = y_count;
    line_column_next  = line_column;
    in_comment_next   = in_comment;
    tok_active_next   = tok_active;
    e_valid = 1'b0; e_kind = pnm_pkg::KIND_PIXEL;
    e_col = '0; e_row = '0; e_complete = 1'b0; e_last = 1'b0;
    do_add = 1'b0; do_check = 1'b0; do_line = 1'b0; add_v = '0;
    comment = 1'b0; len = '0; sidx3 = '0; widx = '0; k = '0;

    // stage one: route the byte
    if (end_of_input) begin
      if (phase <= PH_MAXV || (phase == PH_PIXELS && ascii_mode)) do_line = 1'b1;
    end else if (phase >= PH_DONE) begin
      do_line = 1'b0;
    end else if (phase == PH_PIXELS && !ascii_mode) begin
      do_add = 1'b1;
      add_v  = {8'b0, data_byte};
    end else if (data_byte < pnm_pkg::CH_SPACE) begin
      do_line = 1'b1;
    end else if (!(in_comment || line_column >= pnm_pkg::COL_W'(pnm_pkg::LINE_LIMIT))) begin
      if (line_column == '0 && data_byte == pnm_pkg::CH_HASH) begin
        in_comment_next = 1'b1;
      end else if (phase == PH_PIXELS) begin
        if (pnm_pkg::is_digit(data_byte)) begin
          token_value_next = pnm_pkg::acc_digit(token_value, data_byte);
          tok_active_next  = 1'b1;
        end else if (tok_active) begin
          tok_active_next  = 1'b0;
          token_value_next = '0;
          add_v            = token_value;
          do_add           = 1'b1;
        end
      end else if (phase == PH_MAGIC) begin
        if (line_column == '0) begin
          map_kind_next    = MAP_BAD;
          token_value_next = (data_byte == pnm_pkg::CH_P) ? 16'd1 : 16'd0;
        end else if (line_column == pnm_pkg::COL_W'(1)) begin
          if (token_value == 16'd1 && data_byte >= pnm_pkg::CH_ONE &&
              data_byte <= pnm_pkg::CH_SIX) begin
            k               = data_byte - pnm_pkg::CH_ONE;
            ascii_mode_next = (k < 8'd3);
            map_kind_next   = (k < 8'd3) ? k[1:0] : 2'(k - 8'd3);
          end
          token_value_next = '0;
        end
      end else if (phase == PH_DIMS) begin
        case (sample_index)
          2'd0: begin
            if (pnm_pkg::is_digit(data_byte))
              width_reg_next = pnm_pkg::acc_digit(width_reg, data_byte);
            else
              sample_index_next = (data_byte == pnm_pkg::CH_SPACE) ? 2'd1 : 2'd3;
          end
          2'd1: begin
            if (pnm_pkg::is_digit(data_byte)) begin
              height_reg_next   = pnm_pkg::acc_digit(height_reg, data_byte);
              sample_index_next = 2'd2;
            end else if (data_byte != pnm_pkg::CH_SPACE) begin
              sample_index_next = 2'd3;
            end
          end
          2'd2: begin
            if (pnm_pkg::is_digit(data_byte))
              height_reg_next = pnm_pkg::acc_digit(height_reg, data_byte);
            else
              sample_index_next = 2'd3;
          end
          default: sample_index_next = sample_index;
        endcase
      end else begin
        if (sample_index == 2'd0 && pnm_pkg::is_digit(data_byte))
          max_value_next = pnm_pkg::acc_digit(max_value, data_byte);
        else
          sample_index_next = 2'd3;
      end
      line_column_next = line_column + pnm_pkg::COL_W'(1);
    end

    // line end
    if (do_line) begin
      comment          = in_comment_next;
      len              = line_column_next;
      in_comment_next  = 1'b0;
      line_column_next = '0;
      if (!comment) begin
        case (phase_next)
          PH_MAGIC: begin
            if (len < pnm_pkg::COL_W'(2) || map_kind_next == MAP_BAD) begin
              phase_next = PH_STOPPED;
              e_valid    = 1'b1;
              e_kind     = pnm_pkg::KIND_ERROR;
              e_last     = 1'b1;
            end else begin
              phase_next        = PH_DIMS;
              sample_index_next = '0;
              width_reg_next    = '0;
              height_reg_next   = '0;
            end
          end
          PH_DIMS: begin
            if (map_kind_next == MAP_BIT) begin
              max_value_next = 16'd1;
              do_check       = 1'b1;
            end else begin
              phase_next        = PH_MAXV;
              sample_index_next = '0;
              max_value_next    = '0;
            end
          end
          PH_MAXV: do_check = 1'b1;
          PH_PIXELS: begin
            if (tok_active_next) begin
              tok_active_next  = 1'b0;
              add_v            = token_value_next;
              token_value_next = '0;
              do_add           = 1'b1;
            end
          end
          default: do_check = 1'b0;
        endcase
      end
    end

    if (do_check) begin
      if (width_reg_next == '0 || height_reg_next == '0 || max_value_next == '0) begin
        phase_next = PH_STOPPED;
        e_valid    = 1'b1;
        e_kind     = pnm_pkg::KIND_ERROR;
        e_last     = 1'b1;
      end else begin
        phase_next        = PH_PIXELS;
        x_count_next      = '0;
        y_count_next      = '0;
        sample_index_next = '0;
        token_value_next  = '0;
        tok_active_next   = 1'b0;
      end
    end

    // collect a sample, emit a pixel when the set is full
    if (do_add) begin
      widx = (sample_index_next == 2'd0) ? 2'd0 :
             ((sample_index_next < 2'd3) ? sample_index_next : 2'd2);
      sample_store_next[widx] = add_v;
      sidx3 = {1'b0, sample_index_next} + 3'd1;
      if (sidx3 < ((map_kind_next == MAP_PIX) ? 3'd3 : 3'd1)) begin
        sample_index_next = sidx3[1:0];
      end else begin
        sample_index_next = '0;
        e_valid = 1'b1;
        e_kind  = pnm_pkg::KIND_PIXEL;
        e_col   = x_count_next;
        e_row   = y_count_next;
        e_last  = ({1'b0, x_count_next} + 17'd1 >= {1'b0, width_reg_next}) &&
                  ({1'b0, y_count_next} + 17'd1 >= {1'b0, height_reg_next});
        x_count_next = x_count_next + 16'd1;
        if (x_count_next >= width_reg_next) begin
          x_count_next = '0;
          y_count_next = y_count_next + 16'd1;
          if (y_count_next >= height_reg_next) phase_next = PH_DONE;
        end
      end
    end

    // hold what the result needs before an end of input clears the state
    e_w   = width_reg_next;
    e_h   = height_reg_next;
    e_max = max_value_next;
    e_map = map_kind_next;
    e_s   = sample_store_next;

    if (end_of_input) begin
      if (e_valid) begin
        e_last = 1'b1;
      end else begin
        e_valid    = 1'b1;
        e_last     = 1'b1;
        e_kind     = (phase <= PH_MAXV && phase_next != PH_PIXELS) ?
                     pnm_pkg::KIND_ERROR : pnm_pkg::KIND_STATUS;
        e_complete = (phase == PH_DONE);
      end
      phase_next        = PH_MAGIC;
      ascii_mode_next   = 1'b0;
      map_kind_next     = MAP_BIT;
      width_reg_next    = '0;
      height_reg_next   = '0;
      max_value_next    = 16'd1;
      token_value_next  = '0;
      sample_store_next = '{default: '0};
      sample_index_next = '0;
      x_count_next      = '0;
      y_count_next      = '0;
      line_column_next  = '0;
      in_comment_next   = 1'b0;
      tok_active_next   = 1'b0;
    end
  end

  assign bit_rgb = (e_s[0] != '0) ? 8'hFF : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_MAGIC;
      ascii_mode   <= 1'b0;
      map_kind     <= MAP_BIT;
      width_reg    <= '0;
      height_reg   <= '0;
      max_value    <= 16'd1;
      token_value  <= '0;
      sample_store <= '{default: '0};
      sample_index <= '0;
      x_count      <= '0;
      y_count      <= '0;
      line_column  <= '0;
      in_comment   <= 1'b0;
      tok_active   <= 1'b0;
      st           <= '0;
    end else if (cmd.step) begin
      phase        <= phase_next;
      ascii_mode   <= ascii_mode_next;
      map_kind     <= map_kind_next;
      width_reg    <= width_reg_next;
      height_reg   <= height_reg_next;
      max_value    <= max_value_next;
      token_value  <= token_value_next;
      sample_store <= sample_store_next;
      sample_index <= sample_index_next;
      x_count      <= x_count_next;
      y_count      <= y_count_next;
      line_column  <= line_column_next;
      in_comment   <= in_comment_next;
      tok_active   <= tok_active_next;
      st.res_valid <= e_valid;
      st.scale     <= e_valid && e_kind == pnm_pkg::KIND_PIXEL && e_map != MAP_BIT;
      st.three     <= e_map == MAP_PIX;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && e_valid) begin
      kind         <= e_kind;
      column       <= e_col;
      row          <= e_row;
      image_width  <= e_w;
      image_height <= e_h;
      complete     <= e_complete;
      last         <= e_last;
      rec_s        <= e_s;
      rec_max      <= e_max;
      if (e_kind == pnm_pkg::KIND_PIXEL && e_map == MAP_BIT) begin
        red   <= bit_rgb;
        green <= bit_rgb;
        blue  <= bit_rgb;
      end else begin
        red   <= '0;
        green <= '0;
        blue  <= '0;
      end
    end else if (div_done) begin
      if (!st.three) begin
        red   <= (rec_max == '0) ? 8'h00 : div_quot;
        green <= (rec_max == '0) ? 8'h00 : div_quot;
        blue  <= (rec_max == '0) ? 8'h00 : div_quot;
      end else begin
        case (cmd.comp)
          2'd0:    red   <= div_quot;
          2'd1:    green <= div_quot;
          default: blue  <= div_quot;
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/pnm_to_rgb_decoder.sv =====
// PNM (P1..P6) to RGB decoder. Feed the file one byte per input beat and mark
// end of file with a beat carrying end_of_input; each such beat yields exactly
// one answer (a pixel with last set, a header error or an end status) and then
// returns the block to its reset state. A bad header yields one header error
// beat, after which bytes are dropped until end of input. The block handles one
// byte at a time: each byte is accepted and then evaluated and, when it
// completes a P2/P3/P5/P6 pixel, each color component goes through the
// bit-serial divider that computes sample*255/maxval (one component for gray,
// three for color) before the result is presented; bitmap pixels need no divide.
// A result beat is held until taken, and no byte is accepted meanwhile.
module pnm_to_rgb_decoder (
  input  logic     clk,
  input  logic     rst,
  pnm_in_if.sink   in_ch,
  pnm_out_if.source out_ch
);

  pnm_pkg::pnm_cmd_t    cmd;
  pnm_pkg::pnm_status_t st;
  logic                 div_start;
  logic                 div_done;
  logic [7:0]           div_quot;
  logic [23:0]          div_dividend;
  logic [15:0]          div_divisor;

  // sequencing: accept, evaluate, divide, present
  pnm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .div_done  (div_done),
    .div_start (div_start),
    .cmd       (cmd)
  );

  // header/raster parser and result registers
  pnm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .data_byte    (in_ch.data_byte),
    .end_of_input (in_ch.end_of_input),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .st           (st),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .kind         (out_ch.kind),
    .red          (out_ch.red),
    .green        (out_ch.green),
    .blue         (out_ch.blue),
    .column       (out_ch.column),
    .row          (out_ch.row),
    .image_width  (out_ch.image_width),
    .image_height (out_ch.image_height),
    .complete     (out_ch.complete),
    .last         (out_ch.last)
  );

  // color scaling by maxval
  pnm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

endmodule

// ===== rtl/core/pnm_to_rgb_decoder_chk.sv =====
`include "pnm_to_rgb_decoder_macros.svh"

module pnm_to_rgb_decoder_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic [15:0] column,
  input logic [15:0] row,
  input logic        last
);

  `PNM_ASSERT_NOW(a_nonpix_last, out_valid && kind != pnm_pkg::KIND_PIXEL, last, "non-pixel beat without last")
  `PNM_ASSERT_NOW(a_nonpix_zero, out_valid && kind != pnm_pkg::KIND_PIXEL, red == 8'd0 && green == 8'd0 && blue == 8'd0 && column == 16'd0 && row == 16'd0, "non-pixel beat with payload")
  `PNM_ASSERT_NOW(a_one_item, out_valid, !in_ready, "byte accepted while a result waits")
  `PNM_ASSERT_NEXT(a_eval_gap, in_valid && in_ready, !out_valid, "result shown in the accept cycle")
  `PNM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(red) && $stable(column), "stalled result changed")

endmodule

bind pnm_to_rgb_decoder pnm_to_rgb_decoder_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .kind      (out_ch.kind),
  .red       (out_ch.red),
  .green     (out_ch.green),
  .blue      (out_ch.blue),
  .column    (out_ch.column),
  .row       (out_ch.row),
  .last      (out_ch.last)
);

// ===== dv/pnm_to_rgb_decoder_tb.sv =====
`timescale 1ns / 1ps

module pnm_to_rgb_decoder_tb;

  typedef enum logic [2:0] {
    PH_MAGIC, PH_DIMS, PH_MAXV, PH_PIXELS, PH_DONE, PH_STOPPED
  } parse_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] column;
    logic [15:0] row;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        complete;
    logic        last;
  } rgb_beat_t;

  localparam int unsigned SAT_LIMIT  = 65535;
  localparam int          HOLD_BEATS = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pnm_in_if  in_ch ();
  pnm_out_if out_ch ();

  pnm_to_rgb_decoder DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Decoder shadow state, mirrors the block's parser bit for bit.
  parse_phase_t phase;
  bit           ascii_mode;
  int unsigned  map_kind;
  int unsigned  width_reg, height_reg, max_value, token_value;
  int unsigned  samples[3];
  int unsigned  sample_index, x_count, y_count, line_column;
  bit           in_comment, token_open;

  rgb_beat_t expected_pixels[$];
  int        mismatches  = 0;
  int        beats_sent  = 0;
  int        hold_asks   = 0;
  int        burst_left  = 0;

  // ---------------------------------------------------------------------------
  // Decoder shadow model
  // ---------------------------------------------------------------------------
  function automatic void clear_parser();
    phase = PH_MAGIC;
    ascii_mode = 0;
    map_kind = 0;
    width_reg = 0;
    height_reg = 0;
    max_value = 1;
    token_value = 0;
    samples = '{0, 0, 0};
    sample_index = 0;
    x_count = 0;
    y_count = 0;
    line_column = 0;
    in_comment = 0;
    token_open = 0;
  endfunction

  function automatic int queue_answer(logic [1:0] kind, int unsigned r, int unsigned g,
                                      int unsigned b, int unsigned col, int unsigned row,
                                      bit complete, bit last);
    rgb_beat_t e;
    e.kind = kind;
    e.red = r[7:0];
    e.green = g[7:0];
    e.blue = b[7:0];
    e.column = col[15:0];
    e.row = row[15:0];
    e.image_width = width_reg[15:0];
    e.image_height = height_reg[15:0];
    e.complete = complete;
    e.last = last;
    expected_pixels.push_back(e);
    return 1;
  endfunction

  function automatic bit digit_char(int unsigned c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int unsigned push_digit(int unsigned v, int unsigned c);
    int unsigned r;
    r = v * 10 + (c - "0");
    return r > SAT_LIMIT ? SAT_LIMIT : r;
  endfunction

  function automatic int unsigned to_intensity(int unsigned s);
    if (map_kind == 0) return s != 0 ? 255 : 0;
    if (max_value == 0) return 0;
    return ((s * 255) / max_value) & 255;
  endfunction

  function automatic int store_sample(int unsigned v);
    int unsigned need, r, g, b, col, row;
    bit fin;
    need = (map_kind == 2) ? 3 : 1;
    samples[(sample_index & 3) != 0 ? (sample_index < 3 ? sample_index : 2) : 0] = v;
    sample_index++;
    if (sample_index < need) return 0;
    sample_index = 0;
    r = to_intensity(samples[0]);
    g = (need == 3) ? to_intensity(samples[1]) : r;
    b = (need == 3) ? to_intensity(samples[2]) : r;
    col = x_count;
    row = y_count;
    fin = (x_count + 1 >= width_reg) && (y_count + 1 >= height_reg);
    x_count++;
    if (x_count >= width_reg) begin
      x_count = 0;
      y_count++;
      if (y_count >= height_reg) phase = PH_DONE;
    end
    return queue_answer(pnm_pkg::KIND_PIXEL, r, g, b, col, row, 1'b0, fin);
  endfunction

  function automatic int close_token();
    int unsigned v;
    if (!token_open) return 0;
    token_open = 0;
    v = token_value;
    token_value = 0;
    return store_sample(v);
  endfunction

  function automatic int validate_header();
    if (width_reg == 0 || height_reg == 0 || max_value == 0) begin
      phase = PH_STOPPED;
      return queue_answer(pnm_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 1'b0, 1'b1);
    end
    phase = PH_PIXELS;
    x_count = 0;
    y_count = 0;
    sample_index = 0;
    token_value = 0;
    token_open = 0;
    return 0;
  endfunction

  function automatic int end_of_line();
    bit was_comment;
    int unsigned len;
    int n;
    was_comment = in_comment;
    len = line_column;
    n = 0;
    in_comment = 0;
    line_column = 0;
    if (was_comment) return 0;
    case (phase)
      PH_MAGIC: begin
        if (len < 2 || map_kind == 3) begin
          phase = PH_STOPPED;
          n = queue_answer(pnm_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 1'b0, 1'b1);
        end else begin
          phase = PH_DIMS;
          sample_index = 0;
          width_reg = 0;
          height_reg = 0;
        end
      end
      PH_DIMS: begin
        if (map_kind == 0) begin
          max_value = 1;
          n = validate_header();
        end else begin
          phase = PH_MAXV;
          sample_index = 0;
          max_value = 0;
        end
      end
      PH_MAXV:   n = validate_header();
      PH_PIXELS: n = close_token();
      default: ;
    endcase
    return n;
  endfunction

  function automatic void parse_header_char(int unsigned c);
    if (phase == PH_MAGIC) begin
      if (line_column == 0) begin
        map_kind = 3;
        token_value = (c == "P") ? 1 : 0;
      end else if (line_column == 1) begin
        if (token_value == 1 && c >= "1" && c <= "6") begin
          ascii_mode = (c - "1") < 3;
          map_kind = (c - "1") % 3;
        end
        token_value = 0;
      end
    end else if (phase == PH_DIMS) begin
      case (sample_index)
        0: if (digit_char(c)) width_reg = push_digit(width_reg, c);
           else sample_index = (c == " ") ? 1 : 3;
        1: if (digit_char(c)) begin
             height_reg = push_digit(height_reg, c);
             sample_index = 2;
           end else if (c != " ") begin
             sample_index = 3;
           end
        2: if (digit_char(c)) height_reg = push_digit(height_reg, c);
           else sample_index = 3;
        default: ;
      endcase
    end else begin
      if (sample_index == 0 && digit_char(c)) max_value = push_digit(max_value, c);
      else sample_index = 3;
    end
  endfunction

  function automatic int parse_text_char(int unsigned c);
    int n;
    n = 0;
    if (in_comment || line_column >= pnm_pkg::LINE_LIMIT) return 0;
    if (line_column == 0 && c == "#") begin
      in_comment = 1;
    end else if (phase == PH_PIXELS) begin
      if (digit_char(c)) begin
        token_value = push_digit(token_value, c);
        token_open = 1;
      end else begin
        n = close_token();
      end
    end else begin
      parse_header_char(c);
    end
    line_column++;
    return n;
  endfunction

  function automatic void decode_beat(logic [7:0] data, logic eof);
    int n, first_new;
    n = 0;
    if (eof) begin
      if (phase <= PH_MAXV) begin
        n = end_of_line();
        if (n == 0) begin
          if (phase == PH_PIXELS)
            void'(queue_answer(pnm_pkg::KIND_STATUS, 0, 0, 0, 0, 0, 1'b0, 1'b1));
          else
            void'(queue_answer(pnm_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 1'b0, 1'b1));
        end
      end else if (phase == PH_PIXELS) begin
        first_new = expected_pixels.size();
        if (ascii_mode) n = end_of_line();
        // a trailing token that closes a pixel becomes the final answer
        if (n == 1) expected_pixels[first_new].last = 1'b1;
        else void'(queue_answer(pnm_pkg::KIND_STATUS, 0, 0, 0, 0, 0, 1'b0, 1'b1));
      end else begin
        void'(queue_answer(pnm_pkg::KIND_STATUS, 0, 0, 0, 0, 0, phase == PH_DONE, 1'b1));
      end
      clear_parser();
      return;
    end
    if (phase >= PH_DONE) return;
    if (phase == PH_PIXELS && !ascii_mode) void'(store_sample(32'(data)));
    else if (data < 8'h20) void'(end_of_line());
    else void'(parse_text_char(32'(data)));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of beats separated by random gaps
  // ---------------------------------------------------------------------------
  task automatic send_beat(logic [7:0] data, logic eof);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= data;
    in_ch.end_of_input <= eof;
    do @(posedge clk); while (!in_ch.ready);
    decode_beat(data, eof);
    beats_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic send_eof();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Stop offering and wait until every predicted beat has been taken.
  task automatic drain_results();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern plus an occasional long hold-off
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  int hold_done = 0;
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_done < hold_asks) begin
      out_ch.ready <= 1'b0;
      hold_left <= HOLD_BEATS;
      hold_done <= hold_done + 1;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(10, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each taken result beat with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rgb_beat_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.kind, out_ch.red, out_ch.green, out_ch.blue, out_ch.column,
              out_ch.row, out_ch.image_width, out_ch.image_height, out_ch.complete,
              out_ch.last};
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------
  // Malformed headers: bad magic, short magic line, zero sizes, early eof.
  task automatic test_bad_headers();
    send_text("Q3\n");             send_eof();
    send_text("P7\n");             send_eof();
    send_text("P\n");              send_eof();
    send_text("P2\n0 4\n9\n");     send_eof();
    send_text("P2\n3 2\n0\n");     send_eof();
    send_text("P1\n\n");           send_eof();
    send_text("P3\nx 2\n");        send_eof();
    send_text("P6\n2 2");          send_eof();
    send_eof();
  endtask

  // Comments, CR line ends, oversize numbers, and a line past the column limit.
  task automatic test_header_forms();
    string pad;
    pad = "#";
    for (int i = 0; i < 300; i++) pad = {pad, "c"};
    send_text({pad, "\rP5 junk\r# note\n2  1 tail\n99999999\n"});
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h41, 1'b0);
    send_eof();
    pad = "255";
    for (int i = 0; i < 300; i++) pad = {pad, "7"};
    send_text({"P2\n1 1\n", pad, "\n"});
    send_text("200\n");
    send_eof();
  endtask

  // Binary raster: extremes, bitmap as whole bytes, extra data after the image.
  task automatic test_binary_raster();
    send_text("P6\n2 1\n255\n");
    send_beat(8'h00, 1'b0); send_beat(8'hFF, 1'b0); send_beat(8'h80, 1'b0);
    send_beat(8'h0A, 1'b0); send_beat(8'h01, 1'b0); send_beat(8'hFE, 1'b0);
    send_beat(8'h55, 1'b0);
    send_eof();
    send_text("P4\n3 1\n");
    send_beat(8'h00, 1'b0); send_beat(8'h01, 1'b0); send_beat(8'hFF, 1'b0);
    send_eof();
    send_text("P5\n2 2\n65535\n");
    send_beat(8'hFF, 1'b0); send_beat(8'h00, 1'b0);
    send_eof();
  endtask

  // ASCII raster: tokens, separators, saturation, a token closed by eof.
  task automatic test_ascii_raster();
    send_text("P1\n3 1\n0 1\n7\n");
    send_eof();
    send_text("P2\n2 1\n7\n7,3");
    send_eof();
    send_text("P3\n1 2\n1\n1 0 1\n\n0 1 0 999999");
    send_eof();
    send_text("P2\n1 1\n65535\n#12\n65535 8");
    send_eof();
  endtask

  // One random well-formed (mostly) image, or noise.
  task automatic send_random_image();
    int fmt, w, h, maxv, comps, n, cut;
    string eol;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 30);
      repeat (n) send_beat(8'($urandom_range(0, 255)), 1'b0);
      send_eof();
      return;
    end
    fmt = $urandom_range(1, 6);
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 4);
    h = $urandom_range(1, 3);
    case ($urandom_range(0, 3))
      0: maxv = 1;
      1: maxv = 255;
      2: maxv = 65535;
      default: maxv = $urandom_range(2, 1000);
    endcase
    eol = ($urandom_range(0, 3) == 0) ? "\r" : "\n";
    if ($urandom_range(0, 3) == 0) send_text({"# ", $sformatf("%0d", $urandom), eol});
    send_text({$sformatf("P%0d", fmt), eol, $sformatf("%0d %0d", w, h), eol});
    if (fmt != 1 && fmt != 4) send_text({$sformatf("%0d", maxv), eol});
    comps = (fmt == 3 || fmt == 6) ? 3 : 1;
    n = w * h * comps;
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n) : n + $urandom_range(0, 2);
    for (int i = 0; i < cut; i++) begin
      if (fmt >= 4) begin
        send_beat(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_text($sformatf("%0d", (fmt == 1) ? $urandom_range(0, 1)
                                              : $urandom_range(0, maxv)));
        // hold the last token open now and then so eof has to close it
        if (i != cut - 1 || $urandom_range(0, 2) != 0)
          send_beat((i % 8 == 7) ? 8'h0A : 8'h20, 1'b0);
      end
    end
    send_eof();
  endtask

  task automatic test_random_images();
    while (beats_sent < 1000) send_random_image();
  endtask

  // Long receiver hold-off while the sender keeps offering beats.
  task automatic test_backpressure();
    hold_asks++;
    send_text("P6\n4 3\n200\n");
    repeat (36) send_beat(8'($urandom_range(0, 255)), 1'b0);
    send_eof();
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    in_ch.valid        <= 1'b0;
    in_ch.data_byte    <= 8'h00;
    in_ch.end_of_input <= 1'b0;
    clear_parser();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_bad_headers();
    test_header_forms();
    test_binary_raster();
    test_ascii_raster();
    drain_results();
    test_backpressure();
    test_random_images();

    @(posedge clk);
    in_ch.valid <= 1'b0;
    waited = 0;
    while (expected_pixels.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
